[design/sdt_pkg.sv]
package sdt_pkg;

  localparam int unsigned AddrW  = 48;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CountW = 5;
  localparam logic [TimeW-1:0] TimeoutReset = 32'd60000;

  typedef enum logic {
    OP_SIGHT = 1'b0,
    OP_POP   = 1'b1
  } op_e;

  typedef struct packed {
    logic              operation;
    logic [AddrW-1:0]  station_address;
    logic [TimeW-1:0]  now_ms;
  } in_item_t;

  typedef struct packed {
    logic              arrived;
    logic              queued;
    logic              dropped_oldest;
    logic              popped_valid;
    logic [AddrW-1:0]  popped_address;
    logic [CountW-1:0] fresh_count;
  } out_item_t;

endpackage

[design/sdt_in_if.sv]
interface sdt_in_if;
  logic valid;
  logic ready;
  logic operation;
  logic [sdt_pkg::AddrW-1:0] station_address;
  logic [sdt_pkg::TimeW-1:0] now_ms;

  modport source (output valid, operation, station_address, now_ms, input ready);
  modport sink (input valid, operation, station_address, now_ms, output ready);
endinterface

[design/sdt_out_if.sv]
interface sdt_out_if;
  logic valid;
  logic ready;
  logic arrived;
  logic queued;
  logic dropped_oldest;
  logic popped_valid;
  logic [sdt_pkg::AddrW-1:0] popped_address;
  logic [sdt_pkg::CountW-1:0] fresh_count;

  modport source (output valid, arrived, queued, dropped_oldest, popped_valid,
                  popped_address, fresh_count, input ready);
  modport sink (input valid, arrived, queued, dropped_oldest, popped_valid,
                popped_address, fresh_count, output ready);
endinterface

[design/sighting_dedup_tables.sv]
// Channel  Dir  Payload
// in_i     in   operation, station_address, now_ms
// out_o    out  arrived, queued, dropped_oldest, popped_valid, popped_address, fresh_count
// cfg      in   cfg_we_i / cfg_data_i (stale_timeout_ms)
// A sighting in the back end scans the V filled visible entries, writes its visible slot,
// scans the P pending entries and, unless the address is already pending, appends it,
// first shifting out the head when the queue is full. A pop scans the visible entries
// and shifts the queue head out, skipping the shift on an empty queue.
// Reset clears the fill counts and the timeout returns to 60000.
// Input stays accepted into a two-entry queue while a result waits on out_o, until that queue is full.
module sighting_dedup_tables #(
  parameter int unsigned VISIBLE_ENTRIES = 16,
  parameter int unsigned PENDING_ENTRIES = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [sdt_pkg::TimeW-1:0] cfg_data_i,
  sdt_in_if.sink                    in_i,
  sdt_out_if.source                 out_o
);
  logic [sdt_pkg::TimeW-1:0] timeout_q;
  logic item_valid, item_take, res_valid;
  sdt_pkg::in_item_t item;
  sdt_pkg::out_item_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) timeout_q <= sdt_pkg::TimeoutReset;
    else if (cfg_we_i) timeout_q <= cfg_data_i;
  end

  sdt_front u_front (
    .clk_i, .rst_ni, .in_i,
    .item_valid_o(item_valid), .item_o(item), .item_take_i(item_take)
  );

  sdt_back #(.VISIBLE_ENTRIES(VISIBLE_ENTRIES), .PENDING_ENTRIES(PENDING_ENTRIES)) u_back (
    .clk_i, .rst_ni, .timeout_i(timeout_q),
    .item_valid_i(item_valid), .item_i(item), .item_take_o(item_take),
    .res_valid_o(res_valid), .res_o(res), .res_take_i(out_o.ready)
  );

  assign out_o.valid          = res_valid;
  assign out_o.arrived        = res.arrived;
  assign out_o.queued         = res.queued;
  assign out_o.dropped_oldest = res.dropped_oldest;
  assign out_o.popped_valid   = res.popped_valid;
  assign out_o.popped_address = res.popped_address;
  assign out_o.fresh_count    = res.fresh_count;
endmodule

[design/sdt_front.sv]
// Front end: takes transfers into a two-entry queue toward the back end.
module sdt_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  sdt_in_if.sink              in_i,
  output logic                item_valid_o,
  output sdt_pkg::in_item_t   item_o,
  input  logic                item_take_i
);
  sdt_pkg::in_item_t q_mem [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign in_i.ready   = (cnt_q != 2'd2);
  assign push         = in_i.valid && in_i.ready;
  assign item_valid_o = (cnt_q != 2'd0);
  assign pop          = item_valid_o && item_take_i;
  assign item_o       = q_mem[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wp_q] <= '{operation: in_i.operation, station_address: in_i.station_address,
                       now_ms: in_i.now_ms};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

[design/sdt_back.sv]
// Back end: walks the visible table and the pending queue one entry a cycle.
module sdt_back #(
  parameter int unsigned VISIBLE_ENTRIES = 16,
  parameter int unsigned PENDING_ENTRIES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [sdt_pkg::TimeW-1:0]     timeout_i,
  input  logic                          item_valid_i,
  input  sdt_pkg::in_item_t             item_i,
  output logic                          item_take_o,
  output logic                          res_valid_o,
  output sdt_pkg::out_item_t            res_o,
  input  logic                          res_take_i
);
  localparam int unsigned VW = (VISIBLE_ENTRIES > 1) ? $clog2(VISIBLE_ENTRIES) : 1;
  localparam int unsigned PW = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
  localparam int unsigned VCW = $clog2(VISIBLE_ENTRIES + 1);
  localparam int unsigned PCW = $clog2(PENDING_ENTRIES + 1);
  localparam logic [VCW-1:0] VFull = VCW'(VISIBLE_ENTRIES);
  localparam logic [PCW-1:0] PFull = PCW'(PENDING_ENTRIES);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_VSCAN = 3'd1; // lookup, min search, fresh count
  localparam logic [2:0] S_VWR   = 3'd2;
  localparam logic [2:0] S_PSCAN = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_PWR   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [sdt_pkg::AddrW-1:0] vaddr_mem [VISIBLE_ENTRIES];
  logic [sdt_pkg::TimeW-1:0] vtime_mem [VISIBLE_ENTRIES];
  logic [sdt_pkg::AddrW-1:0] paddr_mem [PENDING_ENTRIES];

  logic [2:0] st_q;
  sdt_pkg::in_item_t it_q;
  logic [VCW-1:0] vused_q;
  logic [PCW-1:0] pused_q;
  logic [VCW-1:0] vi_q;
  logic [PCW-1:0] pi_q;
  logic hit_q, stale_hit_q, already_q, drop_q;
  logic [VW-1:0] hit_idx_q, min_idx_q;
  logic [sdt_pkg::TimeW-1:0] min_t_q;
  logic [VCW-1:0] fresh_q;
  logic [sdt_pkg::AddrW-1:0] pop_addr_q;
  logic out_valid_q;
  sdt_pkg::out_item_t out_q;

  logic [VW-1:0] vi;
  logic [PW-1:0] pi;
  logic [sdt_pkg::TimeW-1:0] age;
  logic e_stale;
  logic [VW-1:0] slot;
  logic [sdt_pkg::TimeW-1:0] slot_age;
  logic slot_stale;
  logic [VCW-1:0] fresh_new;

  assign vi  = vi_q[VW-1:0];
  assign pi  = pi_q[PW-1:0];
  assign age = it_q.now_ms - vtime_mem[vi];
  assign e_stale = (age >= timeout_i);
  assign item_take_o = (st_q == S_IDLE) && !out_valid_q;
  assign res_valid_o = out_valid_q;
  assign res_o = out_q;
  // The written entry is fresh now unless the timeout is zero.
  assign fresh_new = (timeout_i != '0) ? VCW'(1) : '0;
  assign slot = hit_q ? hit_idx_q : ((vused_q == VFull) ? min_idx_q : vused_q[VW-1:0]);
  assign slot_age = it_q.now_ms - vtime_mem[slot];
  assign slot_stale = (slot_age >= timeout_i);

  always_ff @(posedge clk_i) begin
    if (st_q == S_VWR) begin
      vaddr_mem[slot] <= it_q.station_address;
      vtime_mem[slot] <= it_q.now_ms;
    end
    if (st_q == S_SHIFT && pi_q < pused_q) paddr_mem[pi - PW'(1)] <= paddr_mem[pi];
    if (st_q == S_PWR) paddr_mem[pused_q[PW-1:0]] <= it_q.station_address;
  end

  always_ff @(posedge clk_i) begin
    if (item_take_o && item_valid_i) it_q <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; vused_q <= '0; pused_q <= '0; vi_q <= '0; pi_q <= '0;
      hit_q <= 1'b0; stale_hit_q <= 1'b0; already_q <= 1'b0; drop_q <= 1'b0;
      hit_idx_q <= '0; min_idx_q <= '0; min_t_q <= '0; fresh_q <= '0;
      pop_addr_q <= '0; out_valid_q <= 1'b0; out_q <= '0;
    end else begin
      if (out_valid_q && res_take_i) out_valid_q <= 1'b0;
      unique case (st_q)
        S_IDLE: begin
          if (item_valid_i && item_take_o) begin
            vi_q <= '0; pi_q <= '0; hit_q <= 1'b0; stale_hit_q <= 1'b0;
            already_q <= 1'b0; drop_q <= 1'b0; fresh_q <= '0;
            min_idx_q <= '0; min_t_q <= '1;
            st_q <= S_VSCAN;
          end
        end
        S_VSCAN: begin
          if (vi_q == vused_q) begin
            pi_q <= PCW'(1);
            // A pop latches the head before the shift and skips the shift when empty.
            if (it_q.operation == sdt_pkg::OP_POP) begin
              drop_q <= (pused_q != '0);
              pop_addr_q <= paddr_mem[PW'(0)];
              st_q <= (pused_q == '0) ? S_OUT : S_SHIFT;
            end else st_q <= S_VWR;
          end else begin
            if (!e_stale) fresh_q <= fresh_q + VCW'(1);
            if (it_q.operation == sdt_pkg::OP_SIGHT && !hit_q &&
                vaddr_mem[vi] == it_q.station_address) begin
              hit_q <= 1'b1; hit_idx_q <= vi; stale_hit_q <= e_stale;
            end
            if (vtime_mem[vi] < min_t_q || vi_q == '0) begin
              min_t_q <= vtime_mem[vi]; min_idx_q <= vi;
            end
            vi_q <= vi_q + VCW'(1);
          end
        end
        S_VWR: begin
          // Replace the contribution of the overwritten entry in the count.
          if (hit_q || vused_q == VFull) begin
            fresh_q <= fresh_q - (slot_stale ? VCW'(0) : VCW'(1)) + fresh_new;
          end else begin
            fresh_q <= fresh_q + fresh_new;
            vused_q <= vused_q + VCW'(1);
          end
          pi_q <= '0;
          st_q <= S_PSCAN;
        end
        S_PSCAN: begin
          if (pi_q == pused_q) begin
            if (already_q) st_q <= S_OUT;
            else if (pused_q == PFull) begin
              drop_q <= 1'b1; pi_q <= PCW'(1); st_q <= S_SHIFT;
            end else st_q <= S_PWR;
          end else begin
            if (paddr_mem[pi] == it_q.station_address) already_q <= 1'b1;
            pi_q <= pi_q + PCW'(1);
          end
        end
        S_SHIFT: begin
          if (pi_q >= pused_q) begin
            pused_q <= pused_q - PCW'(1);
            st_q <= (it_q.operation == sdt_pkg::OP_POP) ? S_OUT : S_PWR;
          end else pi_q <= pi_q + PCW'(1);
        end
        S_PWR: begin
          pused_q <= pused_q + PCW'(1);
          st_q <= S_OUT;
        end
        S_OUT: begin
          out_valid_q <= 1'b1;
          out_q.fresh_count <= (fresh_q > VCW'(31)) ? 5'd31 : 5'(fresh_q);
          if (it_q.operation == sdt_pkg::OP_SIGHT) begin
            out_q.arrived <= !hit_q || stale_hit_q;
            out_q.queued <= !already_q;
            out_q.dropped_oldest <= drop_q;
            out_q.popped_valid <= 1'b0;
            out_q.popped_address <= '0;
          end else begin
            out_q.arrived <= 1'b0; out_q.queued <= 1'b0; out_q.dropped_oldest <= 1'b0;
            out_q.popped_valid <= drop_q;
            out_q.popped_address <= drop_q ? pop_addr_q : '0;
          end
          st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end
endmodule

[design/sdt_checker.sv]
module sdt_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic arrived_i,
  input logic queued_i,
  input logic dropped_oldest_i,
  input logic popped_valid_i,
  input logic [sdt_pkg::AddrW-1:0] popped_address_i
);
  // A pop result never reports sighting flags.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && popped_valid_i |-> !arrived_i && !queued_i && !dropped_oldest_i)
    else $error("pop result with sighting flags");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && dropped_oldest_i |-> queued_i)
    else $error("drop without append");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !popped_valid_i |-> popped_address_i == '0)
    else $error("address without pop");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn");
endmodule

bind sighting_dedup_tables sdt_checker u_chk (
  .clk_i, .rst_ni, .out_valid_i(out_o.valid), .out_ready_i(out_o.ready),
  .arrived_i(out_o.arrived), .queued_i(out_o.queued),
  .dropped_oldest_i(out_o.dropped_oldest),
  .popped_valid_i(out_o.popped_valid), .popped_address_i(out_o.popped_address)
);

[bench/sighting_dedup_tables_tb.sv]
`timescale 1ns / 1ps

module sighting_dedup_tables_tb;

  localparam int unsigned VisN = 16;
  localparam int unsigned PendN = 16;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [sdt_pkg::TimeW-1:0] cfg_data_i;

  sdt_in_if in_if ();
  sdt_out_if out_if ();

  sighting_dedup_tables u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Shadow copy of the tables and the timeout register.
  logic [sdt_pkg::AddrW-1:0] vis_addr[VisN];
  logic [sdt_pkg::TimeW-1:0] vis_seen[VisN];
  int unsigned vis_used;
  logic [sdt_pkg::AddrW-1:0] pend_addr[PendN];
  int unsigned pend_used;
  logic [sdt_pkg::TimeW-1:0] timeout_ms;

  sdt_pkg::out_item_t pending_results[$];
  int unsigned errors;
  bit idle_on;
  int unsigned stall_left;
  logic [sdt_pkg::TimeW-1:0] clock_ms;

  function automatic bit aged_out(logic [sdt_pkg::TimeW-1:0] last,
                                  logic [sdt_pkg::TimeW-1:0] now);
    logic [sdt_pkg::TimeW-1:0] age;
    age = now - last;
    return age >= timeout_ms;
  endfunction

  function automatic logic [sdt_pkg::AddrW-1:0] rand_addr();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[sdt_pkg::AddrW-1:0];
  endfunction

  function automatic sdt_pkg::out_item_t predict_step(sdt_pkg::in_item_t it);
    sdt_pkg::out_item_t r;
    int unsigned slot;
    bit hit;
    bit listed;
    int unsigned fresh;
    r = '0;
    hit = 1'b0;
    listed = 1'b0;
    fresh = 0;
    if (it.operation == sdt_pkg::OP_SIGHT) begin
      for (int i = 0; i < vis_used; i++) begin
        if (!hit && vis_addr[i] == it.station_address) begin
          hit = 1'b1;
          r.arrived = aged_out(vis_seen[i], it.now_ms);
          vis_seen[i] = it.now_ms;
        end
      end
      if (!hit) begin
        if (vis_used >= VisN) begin
          slot = 0;
          for (int i = 1; i < VisN; i++)
            if (vis_seen[i] < vis_seen[slot]) slot = i;
        end else begin
          slot = vis_used;
          vis_used++;
        end
        vis_addr[slot] = it.station_address;
        vis_seen[slot] = it.now_ms;
        r.arrived = 1'b1;
      end
      for (int i = 0; i < pend_used; i++)
        if (pend_addr[i] == it.station_address) listed = 1'b1;
      if (!listed) begin
        if (pend_used >= PendN) begin
          for (int i = 1; i < pend_used; i++) pend_addr[i-1] = pend_addr[i];
          pend_used--;
          r.dropped_oldest = 1'b1;
        end
        pend_addr[pend_used] = it.station_address;
        pend_used++;
        r.queued = 1'b1;
      end
    end else if (pend_used > 0) begin
      r.popped_valid = 1'b1;
      r.popped_address = pend_addr[0];
      for (int i = 1; i < pend_used; i++) pend_addr[i-1] = pend_addr[i];
      pend_used--;
    end
    for (int i = 0; i < vis_used; i++)
      if (!aged_out(vis_seen[i], it.now_ms)) fresh++;
    r.fresh_count = (fresh > 31) ? 5'd31 : fresh[sdt_pkg::CountW-1:0];
    return r;
  endfunction

  task automatic send_item(sdt_pkg::op_e op, logic [sdt_pkg::AddrW-1:0] addr,
                           logic [sdt_pkg::TimeW-1:0] now);
    sdt_pkg::in_item_t it;
    int unsigned gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.operation <= op;
    in_if.station_address <= addr;
    in_if.now_ms <= now;
    do @(posedge clk_i); while (!in_if.ready);
    it.operation = op;
    it.station_address = addr;
    it.now_ms = now;
    pending_results.insert(pending_results.size(), predict_step(it));
  endtask

  task automatic sight(logic [sdt_pkg::AddrW-1:0] addr, logic [sdt_pkg::TimeW-1:0] now);
    send_item(sdt_pkg::OP_SIGHT, addr, now);
  endtask

  task automatic pop_item(logic [sdt_pkg::TimeW-1:0] now);
    send_item(sdt_pkg::OP_POP, rand_addr(), now);
  endtask

  // Configuration changes only once the block has drained.
  task automatic set_timeout(logic [sdt_pkg::TimeW-1:0] value);
    in_if.valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (40) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    timeout_ms = value;
  endtask

  task automatic test_basic_hits_and_pops();
    pop_item(32'd0);
    sight('0, 32'd0);
    sight('0, 32'd5);
    sight('1, 32'hFFFF_FFFF);
    pop_item(32'd10);
    pop_item(32'd10);
    pop_item(32'd11);
  endtask

  task automatic test_timeout_extremes();
    set_timeout(32'd1);
    sight('1, 32'd0);
    sight('1, 32'd0);
    set_timeout(32'hFFFF_FFFF);
    sight('1, 32'hFFFF_FFFE);
    sight('0, 32'h8000_0000);
  endtask

  // Sixteen new stations overflow both tables; repeated timestamps force ties.
  task automatic test_eviction_and_overflow();
    set_timeout(32'd60000);
    for (int k = 0; k < 16; k++)
      sight(rand_addr() ^ {k[15:0], 32'h0}, 32'd100 + 32'(k % 8));
  endtask

  task automatic test_random(int unsigned n, logic [sdt_pkg::TimeW-1:0] tmo,
                             bit hold_midway);
    logic [sdt_pkg::AddrW-1:0] pool[24];
    int unsigned pick;
    set_timeout(tmo);
    foreach (pool[i]) pool[i] = rand_addr();
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) clock_ms += $urandom_range(0, 30);
      else if (pick < 90) clock_ms += $urandom_range(0, 300);
      else if (pick < 97) clock_ms += $urandom_range(0, 120000);
      else clock_ms = $urandom;
      if (hold_midway && k == n / 2) begin
        in_if.valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(posedge clk_i);
      end
      pick = $urandom_range(0, 99);
      if (pick < 30) pop_item(clock_ms);
      else if (pick < 87) sight(pool[$urandom_range(0, 23)], clock_ms);
      else sight(rand_addr(), clock_ms);
    end
  endtask

  always @(posedge clk_i) begin
    sdt_pkg::out_item_t exp_r;
    if (out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_if.arrived !== exp_r.arrived || out_if.queued !== exp_r.queued ||
            out_if.dropped_oldest !== exp_r.dropped_oldest ||
            out_if.popped_valid !== exp_r.popped_valid ||
            out_if.popped_address !== exp_r.popped_address ||
            out_if.fresh_count !== exp_r.fresh_count) begin
          errors++;
          if (errors <= 10)
            $display("mismatch at %0t: exp arr=%0b q=%0b drop=%0b pv=%0b pa=%h fc=%0d, ",
                     $realtime, exp_r.arrived, exp_r.queued, exp_r.dropped_oldest,
                     exp_r.popped_valid, exp_r.popped_address, exp_r.fresh_count,
                     "got arr=%0b q=%0b drop=%0b pv=%0b pa=%h fc=%0d",
                     out_if.arrived, out_if.queued, out_if.dropped_oldest,
                     out_if.popped_valid, out_if.popped_address, out_if.fresh_count);
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 11);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  initial begin
    #10ms;
    $display("sighting_dedup_tables regression: fail");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.operation = sdt_pkg::OP_SIGHT;
    in_if.station_address = '0;
    in_if.now_ms = '0;
    out_if.ready = 1'b0;
    vis_used = 0;
    pend_used = 0;
    timeout_ms = sdt_pkg::TimeoutReset;
    errors = 0;
    idle_on = 1'b1;
    stall_left = 0;
    clock_ms = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_hits_and_pops();
    test_timeout_extremes();
    test_eviction_and_overflow();
    test_random(180, 32'd50, 1'b0);
    test_random(150, 32'd1, 1'b1);
    test_random(150, 32'hFFFF_FFFF, 1'b0);
    test_random(150, $urandom_range(2, 500), 1'b0);
    idle_on = 1'b0;
    test_random(240, 32'd60000, 1'b0);

    in_if.valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("sighting_dedup_tables regression: pass");
    end else begin
      $display("sighting_dedup_tables regression: fail");
    end
    $finish;
  end

endmodule

[sighting_dedup_tables.f]
design/sdt_pkg.sv
design/sdt_in_if.sv
design/sdt_out_if.sv
design/sdt_front.sv
design/sdt_back.sv
design/sighting_dedup_tables.sv
design/sdt_checker.sv
bench/sighting_dedup_tables_tb.sv
